// ===== rtl/core/mac_pkg.sv =====
// shared constants, types and codes of the moving average crossover core
package mac_pkg;

	localparam int MAX_WINDOW_DEF = 64;

	localparam int PRICE_W  = 24;
	localparam int SUM_W    = 30;
	localparam int PERIOD_W = 7;
	localparam int DEC_W    = 3;
	localparam int PROD_W   = SUM_W + PERIOD_W;

	localparam logic [PERIOD_W-1:0] SHORT_PERIOD_RST = 7'd10;
	localparam logic [PERIOD_W-1:0] LONG_PERIOD_RST  = 7'd30;

	localparam int CFG_INDEX_W = 1;
	localparam int MID_DEPTH   = 4;
	localparam int MID_CNT_W   = $clog2(MID_DEPTH + 1);
	localparam int OUT_DEPTH   = 2;
	localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SHORT_PERIOD,
		REG_LONG_PERIOD
	} cfg_reg_t;

	typedef enum logic [DEC_W-1:0] {
		DEC_NOT_READY,
		DEC_ZERO_AVG,
		DEC_BUY,
		DEC_SELL,
		DEC_NONE
	} decision_t;

	typedef struct packed {
		logic             ready;
		logic [SUM_W-1:0] short_sum;
		logic [SUM_W-1:0] long_sum;
	} mid_entry_t;

	typedef struct packed {
		logic       valid;
		mid_entry_t entry;
	} mid_push_t;

	typedef struct packed {
		decision_t        decision;
		logic [SUM_W-1:0] short_sum;
		logic [SUM_W-1:0] long_sum;
	} result_t;

endpackage

// ===== rtl/core/mac_ram.sv =====
// generic ram, one write port and two registered read-first read ports
module mac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// reads see the contents before a same-edge write
	always_ff @(posedge clk) begin
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

endmodule

// ===== rtl/core/mac_queue.sv =====
// small register queue with occupancy count
module mac_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    head_q;
	logic [PW-1:0]    tail_q;
	logic [CW-1:0]    count_q;

	assign rdata = slot_q[head_q];
	assign empty = (count_q == '0);
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= (tail_q == PW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
			if (pop) begin
				head_q <= (head_q == PW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[tail_q] <= wdata;
		end
	end

endmodule

// ===== rtl/core/mac_front.sv =====
// front end: takes prices, keeps the price ring and the two running window sums
module mac_front #(
	parameter int MAX_WINDOW = mac_pkg::MAX_WINDOW_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            clear,
	input  logic                            push,
	input  logic [mac_pkg::PRICE_W-1:0]     price,
	input  logic [mac_pkg::PERIOD_W-1:0]    short_period,
	input  logic [mac_pkg::PERIOD_W-1:0]    long_period,
	input  logic [mac_pkg::MID_CNT_W-1:0]   mid_count,
	output logic                            full,
	output mac_pkg::mid_push_t              mid_push
);

	localparam int AW = $clog2(MAX_WINDOW);
	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam int IW = ((CW > mac_pkg::PERIOD_W) ? CW : mac_pkg::PERIOD_W) + 1;
	localparam int FW = mac_pkg::MID_CNT_W + 1;

	logic [AW-1:0] pos_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] fill_next;
	logic          accept;

	logic [IW-1:0] pos_ext;
	logic [IW-1:0] fill_ext;
	logic [IW-1:0] fill_next_ext;
	logic [IW-1:0] sp_ext;
	logic [IW-1:0] lp_ext;
	logic [IW-1:0] max_ext;
	logic          use_short;
	logic          use_long;
	logic [AW-1:0] addr_short;
	logic [AW-1:0] addr_long;

	logic [mac_pkg::PRICE_W-1:0] rd_short;
	logic [mac_pkg::PRICE_W-1:0] rd_long;

	logic                        v_s1;
	logic [mac_pkg::PRICE_W-1:0] price_s1;
	logic                        use_short_s1;
	logic                        use_long_s1;
	logic                        sub_short_s1;
	logic                        sub_long_s1;
	logic                        ready_s1;

	logic                       v_s2;
	logic                       ready_s2;
	logic [mac_pkg::SUM_W-1:0]  short_sum_q;
	logic [mac_pkg::SUM_W-1:0]  long_sum_q;
	logic [mac_pkg::SUM_W-1:0]  old_short;
	logic [mac_pkg::SUM_W-1:0]  old_long;
	logic [FW-1:0]              inflight;

	// index of the price that drops out of a window of length per
	function automatic logic [AW-1:0] tail_addr(input logic [IW-1:0] pos,
			input logic [IW-1:0] per, input logic [IW-1:0] depth);
		logic [IW-1:0] d;
		if (pos >= per) begin
			d = pos - per;
		end else begin
			d = pos + depth - per;
		end
		return d[AW-1:0];
	endfunction

	// items in the two stages count against the room left in the queue
	assign inflight = FW'(mid_count) + FW'(v_s1) + FW'(v_s2);
	assign full     = (inflight >= FW'(mac_pkg::MID_DEPTH));
	assign accept   = push && !full;

	assign fill_next     = (fill_q == CW'(MAX_WINDOW)) ? fill_q : fill_q + 1'b1;
	assign pos_ext       = IW'(pos_q);
	assign fill_ext      = IW'(fill_q);
	assign fill_next_ext = IW'(fill_next);
	assign sp_ext        = IW'(short_period);
	assign lp_ext        = IW'(long_period);
	assign max_ext       = IW'(MAX_WINDOW);
	assign use_short     = (sp_ext != '0) && (sp_ext <= max_ext);
	assign use_long      = (lp_ext != '0) && (lp_ext <= max_ext);
	assign addr_short    = tail_addr(pos_ext, sp_ext, max_ext);
	assign addr_long     = tail_addr(pos_ext, lp_ext, max_ext);

	mac_ram #(
		.WIDTH (mac_pkg::PRICE_W),
		.DEPTH (MAX_WINDOW)
	) u_ring (
		.clk     (clk),
		.we      (accept),
		.waddr   (pos_q),
		.wdata   (price),
		.raddr_a (addr_short),
		.raddr_b (addr_long),
		.rdata_a (rd_short),
		.rdata_b (rd_long)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			fill_q <= '0;
			v_s1   <= 1'b0;
		end else begin
			v_s1 <= accept;
			if (clear) begin
				pos_q  <= '0;
				fill_q <= '0;
			end else if (accept) begin
				pos_q  <= (pos_q == AW'(MAX_WINDOW - 1)) ? '0 : pos_q + 1'b1;
				fill_q <= fill_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			price_s1     <= price;
			use_short_s1 <= use_short;
			use_long_s1  <= use_long;
			sub_short_s1 <= (fill_ext >= sp_ext);
			sub_long_s1  <= (fill_ext >= lp_ext);
			ready_s1     <= use_short && use_long &&
			                (fill_next_ext >= sp_ext) && (fill_next_ext >= lp_ext);
		end
	end

	assign old_short = sub_short_s1 ? mac_pkg::SUM_W'(rd_short) : '0;
	assign old_long  = sub_long_s1  ? mac_pkg::SUM_W'(rd_long)  : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			short_sum_q <= '0;
			long_sum_q  <= '0;
		end else begin
			v_s2 <= v_s1;
			if (clear) begin
				short_sum_q <= '0;
				long_sum_q  <= '0;
			end else if (v_s1) begin
				short_sum_q <= use_short_s1 ?
				               short_sum_q - old_short + mac_pkg::SUM_W'(price_s1) : '0;
				long_sum_q  <= use_long_s1 ?
				               long_sum_q - old_long + mac_pkg::SUM_W'(price_s1) : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			ready_s2 <= ready_s1;
		end
	end

	always_comb begin
		mid_push.valid           = v_s2;
		mid_push.entry.ready     = ready_s2;
		mid_push.entry.short_sum = ready_s2 ? short_sum_q : '0;
		mid_push.entry.long_sum  = ready_s2 ? long_sum_q : '0;
	end

endmodule

// ===== rtl/core/mac_back.sv =====
// back end: cross-multiplies the window sums and forms the decision
module mac_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [mac_pkg::PERIOD_W-1:0]  short_period,
	input  logic [mac_pkg::PERIOD_W-1:0]  long_period,
	input  mac_pkg::mid_entry_t           mid_entry,
	input  logic                          mid_empty,
	output logic                          mid_pop,
	input  logic                          out_full,
	output logic                          out_push,
	output mac_pkg::result_t              out_result
);

	logic                          v_s3;
	logic                          ready_s3;
	logic [mac_pkg::SUM_W-1:0]     short_s3;
	logic [mac_pkg::SUM_W-1:0]     long_s3;
	logic [mac_pkg::PROD_W-1:0]    lhs_s3;
	logic [mac_pkg::PROD_W-1:0]    rhs_s3;
	logic                          load_s3;

	assign out_push = v_s3 && !out_full;
	assign load_s3  = !v_s3 || out_push;
	assign mid_pop  = load_s3 && !mid_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (load_s3) begin
			v_s3 <= !mid_empty;
		end
	end

	// short average above long average is short_sum*long_period > long_sum*short_period
	always_ff @(posedge clk) begin
		if (mid_pop) begin
			ready_s3 <= mid_entry.ready;
			short_s3 <= mid_entry.short_sum;
			long_s3  <= mid_entry.long_sum;
			lhs_s3   <= mac_pkg::PROD_W'(mid_entry.short_sum) *
			            mac_pkg::PROD_W'(long_period);
			rhs_s3   <= mac_pkg::PROD_W'(mid_entry.long_sum) *
			            mac_pkg::PROD_W'(short_period);
		end
	end

	always_comb begin
		out_result.short_sum = short_s3;
		out_result.long_sum  = long_s3;
		if (!ready_s3) begin
			out_result.decision = mac_pkg::DEC_NOT_READY;
		end else if (short_s3 == '0 || long_s3 == '0) begin
			out_result.decision = mac_pkg::DEC_ZERO_AVG;
		end else if (lhs_s3 > rhs_s3) begin
			out_result.decision = mac_pkg::DEC_BUY;
		end else if (lhs_s3 < rhs_s3) begin
			out_result.decision = mac_pkg::DEC_SELL;
		end else begin
			out_result.decision = mac_pkg::DEC_NONE;
		end
	end

endmodule

// ===== rtl/core/moving_average_crossover_core.sv =====
// top level of the moving average crossover core
// throughput: one price per cycle while full is low, the running sums being updated once per price
// from the two-port price ring read at the push edge
// reset: periods return to 10 and 30, ring position, fill count and sums clear
// a period write clears the same history; ring contents are never cleared
module moving_average_crossover_core #(
	parameter int MAX_WINDOW = mac_pkg::MAX_WINDOW_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [mac_pkg::PRICE_W-1:0]      price,
	output logic                             empty,
	input  logic                             pop,
	output logic [mac_pkg::DEC_W-1:0]        decision,
	output logic [mac_pkg::SUM_W-1:0]        short_sum,
	output logic [mac_pkg::SUM_W-1:0]        long_sum,
	input  logic                             cfg_we,
	input  logic [mac_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [mac_pkg::PERIOD_W-1:0]     cfg_data
);

	logic [mac_pkg::PERIOD_W-1:0]  short_period_q;
	logic [mac_pkg::PERIOD_W-1:0]  long_period_q;

	mac_pkg::mid_push_t            mid_push;
	mac_pkg::mid_entry_t           mid_entry;
	logic                          mid_pop;
	logic                          mid_empty;
	logic [mac_pkg::MID_CNT_W-1:0] mid_count;

	logic                          out_push;
	logic                          out_full;
	mac_pkg::result_t              out_result;
	mac_pkg::result_t              head_result;
	logic [mac_pkg::OUT_CNT_W-1:0] out_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_period_q <= mac_pkg::SHORT_PERIOD_RST;
			long_period_q  <= mac_pkg::LONG_PERIOD_RST;
		end else if (cfg_we) begin
			unique case (mac_pkg::cfg_reg_t'(cfg_index))
				mac_pkg::REG_SHORT_PERIOD: short_period_q <= cfg_data;
				mac_pkg::REG_LONG_PERIOD:  long_period_q  <= cfg_data;
				default:                   short_period_q <= short_period_q;
			endcase
		end
	end

	mac_front #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.clear        (cfg_we),
		.push         (push),
		.price        (price),
		.short_period (short_period_q),
		.long_period  (long_period_q),
		.mid_count    (mid_count),
		.full         (full),
		.mid_push     (mid_push)
	);

	mac_queue #(
		.WIDTH ($bits(mac_pkg::mid_entry_t)),
		.DEPTH (mac_pkg::MID_DEPTH)
	) u_mid_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push.valid),
		.wdata  (mid_push.entry),
		.pop    (mid_pop),
		.rdata  (mid_entry),
		.empty  (mid_empty),
		.count  (mid_count)
	);

	mac_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.short_period (short_period_q),
		.long_period  (long_period_q),
		.mid_entry    (mid_entry),
		.mid_empty    (mid_empty),
		.mid_pop      (mid_pop),
		.out_full     (out_full),
		.out_push     (out_push),
		.out_result   (out_result)
	);

	assign out_full = (out_count == mac_pkg::OUT_CNT_W'(mac_pkg::OUT_DEPTH));

	mac_queue #(
		.WIDTH ($bits(mac_pkg::result_t)),
		.DEPTH (mac_pkg::OUT_DEPTH)
	) u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_result),
		.pop    (pop && !empty),
		.rdata  (head_result),
		.empty  (empty),
		.count  (out_count)
	);

	assign decision  = head_result.decision;
	assign short_sum = head_result.short_sum;
	assign long_sum  = head_result.long_sum;

`ifndef ASSERT_OFF
	// the front must hold back prices before the middle queue can overflow
	a_mid_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(mid_push.valid && !mid_pop) |->
		(mid_count != mac_pkg::MID_CNT_W'(mac_pkg::MID_DEPTH)))
		else $error("middle queue overflow");

	a_mid_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> !mid_empty)
		else $error("pop from empty middle queue");

	a_out_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> (out_count != mac_pkg::OUT_CNT_W'(mac_pkg::OUT_DEPTH)))
		else $error("result queue overflow");

	// an item not ready carries zero sums
	a_not_ready_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && decision == mac_pkg::DEC_NOT_READY) |->
		(short_sum == '0 && long_sum == '0))
		else $error("not ready item with nonzero sums");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the moving average crossover core
module tb_top;
	import mac_pkg::*;

	localparam int WIN         = MAX_WINDOW_DEF;
	localparam int POS_W       = $clog2(WIN);
	localparam int N_ITEMS     = 1600;
	localparam int QUIET_TAIL  = 200;
	localparam int HOLD_CYCLES = 80;
	localparam int SETTLE      = 8;
	localparam int CYCLE_LIMIT = 250000;

	typedef enum logic {ROW_PRICE, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		cfg_reg_t           sel;
		logic [PRICE_W-1:0] value;
		bit                 typed;
		result_t            want;
	} stim_row_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   push      = 1'b0;
	logic                   full;
	logic [PRICE_W-1:0]     price     = '0;
	logic                   empty;
	logic                   pop       = 1'b0;
	logic [DEC_W-1:0]       decision;
	logic [SUM_W-1:0]       short_sum;
	logic [SUM_W-1:0]       long_sum;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [PERIOD_W-1:0]    cfg_data  = '0;

	// predictor state
	logic [PRICE_W-1:0]  price_ring [WIN];
	logic [POS_W-1:0]    ring_pos   = '0;
	logic [PERIOD_W-1:0] fill_cnt   = '0;
	logic [SUM_W-1:0]    sum_short  = '0;
	logic [SUM_W-1:0]    sum_long   = '0;
	logic [PERIOD_W-1:0] per_short  = SHORT_PERIOD_RST;
	logic [PERIOD_W-1:0] per_long   = LONG_PERIOD_RST;

	result_t     pending_res [$];
	int unsigned cyc        = 0;
	int          err_count  = 0;
	int          n_sent     = 0;
	int          n_checked  = 0;
	int          n_phases   = 0;
	int          dec_seen [8];
	bit          idle_on    = 1'b1;
	bit          hold_ask   = 1'b0;
	int          walk       = 0;
	logic [PRICE_W-1:0] flat_level = '0;

	moving_average_crossover_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.price     (price),
		.empty     (empty),
		.pop       (pop),
		.decision  (decision),
		.short_sum (short_sum),
		.long_sum  (long_sum),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= CYCLE_LIMIT) begin
			$display("tb_top: timeout after %0d cycles", cyc);
			$display("tb_top: errors");
			$finish;
		end
	end

	task automatic flag_err(input string what);
		err_count++;
		$display("tb_top: mismatch at cycle %0d: %s", cyc, what);
	endtask

	function automatic bit period_ok(input logic [PERIOD_W-1:0] per);
		return per != 0 && per <= WIN;
	endfunction

	// running sum before the new price is stored in the ring
	function automatic logic [SUM_W-1:0] window_sum_next(input logic [SUM_W-1:0] sum,
			input logic [PERIOD_W-1:0] per, input logic [PRICE_W-1:0] p);
		logic [POS_W-1:0] tail;
		logic [SUM_W-1:0] s;
		if (!period_ok(per))
			return '0;
		s = sum;
		if (fill_cnt >= per) begin
			tail = ring_pos - per[POS_W-1:0];
			s = s - SUM_W'(price_ring[tail]);
		end
		return s + SUM_W'(p);
	endfunction

	function automatic result_t predict_crossover(input logic [PRICE_W-1:0] p);
		result_t r;
		logic [PROD_W-1:0] lhs, rhs;
		sum_short = window_sum_next(sum_short, per_short, p);
		sum_long = window_sum_next(sum_long, per_long, p);
		price_ring[ring_pos] = p;
		ring_pos = ring_pos + 1'b1;
		if (fill_cnt < WIN)
			fill_cnt = fill_cnt + 1'b1;
		r = '0;
		r.decision = DEC_NOT_READY;
		if (!period_ok(per_short) || !period_ok(per_long) ||
				fill_cnt < per_short || fill_cnt < per_long)
			return r;
		r.short_sum = sum_short;
		r.long_sum = sum_long;
		if (sum_short == 0 || sum_long == 0) begin
			r.decision = DEC_ZERO_AVG;
		end else begin
			// exact comparison of the two averages by cross-multiplying
			lhs = PROD_W'(sum_short) * PROD_W'(per_long);
			rhs = PROD_W'(sum_long) * PROD_W'(per_short);
			if (lhs > rhs)
				r.decision = DEC_BUY;
			else if (lhs < rhs)
				r.decision = DEC_SELL;
			else
				r.decision = DEC_NONE;
		end
		return r;
	endfunction

	function automatic stim_row_t t_row(input logic [PRICE_W-1:0] p, input decision_t d,
			input logic [SUM_W-1:0] s, input logic [SUM_W-1:0] l);
		stim_row_t row;
		row.kind = ROW_PRICE;
		row.sel = REG_SHORT_PERIOD;
		row.value = p;
		row.typed = 1'b1;
		row.want.decision = d;
		row.want.short_sum = s;
		row.want.long_sum = l;
		return row;
	endfunction

	function automatic stim_row_t p_row(input logic [PRICE_W-1:0] p);
		stim_row_t row;
		row = t_row(p, DEC_NOT_READY, '0, '0);
		row.typed = 1'b0;
		return row;
	endfunction

	function automatic stim_row_t c_row(input cfg_reg_t sel, input logic [PERIOD_W-1:0] v);
		stim_row_t row;
		row = p_row(PRICE_W'(v));
		row.kind = ROW_CFG;
		row.sel = sel;
		return row;
	endfunction

	function automatic logic [PRICE_W-1:0] next_price(input int mode);
		case (mode)
			0: return PRICE_W'($urandom);
			1: return ($urandom_range(0, 3) == 0) ? PRICE_W'($urandom_range(0, 255)) : '0;
			2: return ($urandom_range(0, 31) == 0) ? PRICE_W'($urandom) : flat_level;
			3: begin
				// random walk so the averages cross now and then
				walk = walk + int'($urandom_range(0, 8000)) - 4000;
				if (walk < 0)
					walk = 0;
				if (walk > 'hFFFFFF)
					walk = 'hFFFFFF;
				return PRICE_W'(walk);
			end
			default: return ($urandom_range(0, 1) == 1) ? '1 : '0;
		endcase
	endfunction

	task automatic send_price(input logic [PRICE_W-1:0] p, input bit typed, input result_t want);
		result_t predicted;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		push <= 1'b1;
		price <= p;
		@(posedge clk);
		while (full)
			@(posedge clk);
		predicted = predict_crossover(p);
		pending_res.insert(pending_res.size(), typed ? want : predicted);
		n_sent++;
	endtask

	task automatic drain_results();
		push <= 1'b0;
		while (pending_res.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_period(input cfg_reg_t sel, input logic [PERIOD_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (sel == REG_SHORT_PERIOD)
			per_short = v;
		else
			per_long = v;
		ring_pos = '0;
		fill_cnt = '0;
		sum_short = '0;
		sum_long = '0;
	endtask

	// result side: check each popped item against the oldest expectation
	initial begin
		int stall;
		result_t want;
		stall = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				if (pending_res.size() == 0) begin
					flag_err("result with nothing expected");
				end else begin
					want = pending_res.pop_front();
					n_checked++;
					dec_seen[want.decision]++;
					if (decision !== want.decision)
						flag_err($sformatf("decision %0d, expected %0d", decision, want.decision));
					if (short_sum !== want.short_sum)
						flag_err($sformatf("short_sum %0h, expected %0h", short_sum,
							want.short_sum));
					if (long_sum !== want.long_sum)
						flag_err($sformatf("long_sum %0h, expected %0h", long_sum,
							want.long_sum));
				end
			end
			if (stall > 0) begin
				stall--;
				pop <= 1'b0;
			end else if (hold_ask) begin
				hold_ask = 1'b0;
				stall = HOLD_CYCLES - 1;
				pop <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				stall = $urandom_range(0, 7);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		stim_row_t dir_tab [$];
		logic [PERIOD_W-1:0] ps, pl;
		int mode, maxp, n_items;
		dir_tab = '{
			t_row(24'hFFFFFF, DEC_NOT_READY, '0, '0),
			t_row(24'h000000, DEC_NOT_READY, '0, '0),
			c_row(REG_SHORT_PERIOD, 7'd1),
			c_row(REG_LONG_PERIOD, 7'd1),
			t_row(24'h000000, DEC_ZERO_AVG, '0, '0),
			t_row(24'hFFFFFF, DEC_NONE, 30'hFFFFFF, 30'hFFFFFF),
			c_row(REG_LONG_PERIOD, 7'd2),
			t_row(24'd100, DEC_NOT_READY, '0, '0),
			t_row(24'd300, DEC_BUY, 30'd300, 30'd400),
			t_row(24'd100, DEC_SELL, 30'd100, 30'd400),
			c_row(REG_SHORT_PERIOD, 7'd0),
			t_row(24'd5, DEC_NOT_READY, '0, '0),
			t_row(24'd5, DEC_NOT_READY, '0, '0),
			c_row(REG_SHORT_PERIOD, 7'd100),
			c_row(REG_LONG_PERIOD, 7'd1),
			t_row(24'd7, DEC_NOT_READY, '0, '0),
			c_row(REG_SHORT_PERIOD, 7'd127),
			c_row(REG_LONG_PERIOD, 7'd0),
			t_row(24'd0, DEC_NOT_READY, '0, '0),
			c_row(REG_SHORT_PERIOD, 7'd2),
			c_row(REG_LONG_PERIOD, 7'd3),
			p_row(24'd0),
			p_row(24'd0),
			p_row(24'd0),
			p_row(24'd9),
			p_row(24'hFFFFFF)
		};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_CFG) begin
				drain_results();
				write_period(dir_tab[i].sel, dir_tab[i].value[PERIOD_W-1:0]);
			end else begin
				send_price(dir_tab[i].value, dir_tab[i].typed, dir_tab[i].want);
			end
		end

		while (n_sent < N_ITEMS) begin
			case (n_phases)
				0: begin ps = 7'd64;  pl = 7'd64;  end
				1: begin ps = 7'd1;   pl = 7'd64;  end
				2: begin ps = 7'd64;  pl = 7'd1;   end
				3: begin ps = 7'd0;   pl = 7'd64;  end
				4: begin ps = 7'd127; pl = 7'd127; end
				5: begin ps = 7'd65;  pl = 7'd3;   end
				default: begin
					case ($urandom_range(0, 9))
						0: begin
							ps = PERIOD_W'($urandom_range(1, 64));
							pl = PERIOD_W'($urandom_range(1, 64));
						end
						1: begin
							ps = ($urandom_range(0, 1) == 1) ? '0 :
								PERIOD_W'($urandom_range(65, 127));
							pl = PERIOD_W'($urandom_range(1, 20));
						end
						2: begin
							ps = PERIOD_W'($urandom_range(1, 20));
							pl = ($urandom_range(0, 1) == 1) ? '0 :
								PERIOD_W'($urandom_range(65, 127));
						end
						default: begin
							ps = PERIOD_W'($urandom_range(1, 12));
							pl = PERIOD_W'($urandom_range(1, 40));
						end
					endcase
				end
			endcase
			drain_results();
			write_period(REG_SHORT_PERIOD, ps);
			write_period(REG_LONG_PERIOD, pl);
			// long receiver hold while prices keep coming, so the core fills up
			if (n_phases == 1)
				hold_ask = 1'b1;
			n_phases++;
			mode = $urandom_range(0, 4);
			flat_level = PRICE_W'($urandom);
			walk = $urandom_range(0, 'hFFFFFF);
			maxp = (period_ok(ps) && period_ok(pl)) ? ((ps > pl) ? ps : pl) : 0;
			n_items = maxp + $urandom_range(8, 50);
			repeat (n_items) begin
				if (n_sent >= N_ITEMS - QUIET_TAIL)
					idle_on = 1'b0;
				send_price(next_price(mode), 1'b0, '0);
			end
		end

		drain_results();
		$display("tb_top: %0d prices over %0d random period settings, %0d results checked",
			n_sent, n_phases, n_checked);
		$display("tb_top: not ready %0d, zero average %0d, buy %0d, sell %0d, no action %0d",
			dec_seen[DEC_NOT_READY], dec_seen[DEC_ZERO_AVG], dec_seen[DEC_BUY],
			dec_seen[DEC_SELL], dec_seen[DEC_NONE]);
		if (err_count == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
